// ===== rtl/firing_click_voice_mixer_macros.svh =====
// Assertion macros for the engine click mixer.
`ifndef FIRING_CLICK_VOICE_MIXER_MACROS_SVH
`define FIRING_CLICK_VOICE_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define FCVM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fcvm assertion failed");
`define FCVM_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fcvm sequence assertion failed");
`else
`define FCVM_ASSERT(lbl, clk, rst, prop)
`define FCVM_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/fcvm_pkg.sv =====
// Shared constants, codes and control types of the engine click mixer.
`default_nettype none
package fcvm_pkg;
   localparam int MAX_CYLINDERS = 16;
   localparam int CLICK_DEPTH   = 4096;
   localparam int MAX_VOICES    = 16;

   localparam int CYL_W   = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;
   localparam int ADDR_W  = $clog2(CLICK_DEPTH);
   localparam int POS_W   = $clog2(CLICK_DEPTH + 1);
   localparam int VOICE_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int MEM_DEPTH = MAX_CYLINDERS * CLICK_DEPTH;
   localparam int MEM_W   = $clog2(MEM_DEPTH);
   localparam int PROD_W  = 33;
   localparam int ACC_W   = PROD_W + VOICE_W + 1;
   localparam int NUM_W   = 52;
   localparam int DCNT_W  = $clog2(NUM_W);

   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_SET_RPM   = 3'd1;
   localparam logic [2:0] CMD_WR_CLICK  = 3'd2;
   localparam logic [2:0] CMD_WR_SLOT   = 3'd3;
   localparam logic [2:0] CMD_WR_CYL    = 3'd4;

   localparam logic [1:0] REG_CYL_COUNT  = 2'd0;
   localparam logic [1:0] REG_RPM_FACTOR = 2'd1;
   localparam logic [1:0] REG_SAMPLE_RT  = 2'd2;
   localparam logic [1:0] REG_MAX_AMP    = 2'd3;

   typedef struct packed {
      logic accept;
      logic den;
      logic div;
      logic timer;
      logic reduce;
      logic fire;
      logic sub;
      logic mix;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic fire_now;
      logic pos_ge;
      logic div_last;
      logic voice_last;
      logic pipe_busy;
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/firing_click_voice_mixer.sv =====
// Top level of the engine click mixer: controller plus datapath.
//
// req_ channel: one command per transfer (tick, set rpm, click/slot/cylinder
// table writes); accepted when req_valid is high and req_stall is low.
// rsp_ channel: exactly one result per command, held in an output register
// until taken (rsp_valid high, rsp_stall low). A new command is accepted while
// that result still waits; its own result waits for the register to free up.
// csr_ channel: register writes, csr_ready is always high; write only while idle.
// Set rpm runs the bit-serial 52-step interval divider; a tick with a firing
// also walks the cylinder-slot reduction steps, and every tick walks the
// 16 voices one per cycle through the click memory read port and the single
// gain multiplier.
// Throughput: one command at a time, next accepted once the previous leaves
// the sequencer.
// Reset: registers return to defaults, interval never fires, voices idle;
// tables and click memory are undefined until written.
// A stalled receiver holds the result; the block then finishes at most one
// more command and waits.
`default_nettype none
module firing_click_voice_mixer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic [15:0]        req_rpm_value,
   input  wire logic [3:0]         req_slot,
   input  wire logic [3:0]         req_piston,
   input  wire logic [11:0]        req_sample_index,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic [10:0]        req_interval_factor,
   input  wire logic [12:0]        req_click_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_sample_out,
   output logic                    rsp_fired,
   output logic [3:0]              rsp_fired_cylinder,
   output logic                    rsp_dropped,
   output logic                    rsp_clipped,
   output logic [15:0]             rsp_rpm_readback,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [17:0]        csr_data
);
   fcvm_pkg::cmd_type    cmd;
   fcvm_pkg::status_type sts;

   // config transfers are always taken
   assign csr_ready = 1'b1;

   fcvm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   fcvm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_command         (req_command),
      .req_rpm_value       (req_rpm_value),
      .req_slot            (req_slot),
      .req_piston          (req_piston),
      .req_sample_index    (req_sample_index),
      .req_sample_value    (req_sample_value),
      .req_interval_factor (req_interval_factor),
      .req_click_length    (req_click_length),
      .csr_write           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_sample_out      (rsp_sample_out),
      .rsp_fired           (rsp_fired),
      .rsp_fired_cylinder  (rsp_fired_cylinder),
      .rsp_dropped         (rsp_dropped),
      .rsp_clipped         (rsp_clipped),
      .rsp_rpm_readback    (rsp_rpm_readback)
   );
endmodule
`default_nettype wire

// ===== rtl/fcvm_ctrl.sv =====
// Sequencer for tick, set-rpm and table-write commands.
`default_nettype none
`include "firing_click_voice_mixer_macros.svh"
module fcvm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_command,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire fcvm_pkg::status_type sts,
   output fcvm_pkg::cmd_type        cmd
);
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_DEN    = 10'b0000000010,
      ST_DIV    = 10'b0000000100,
      ST_TIMER  = 10'b0000001000,
      ST_REDUCE = 10'b0000010000,
      ST_FIRE   = 10'b0000100000,
      ST_SUB    = 10'b0001000000,
      ST_MIX    = 10'b0010000000,
      ST_DRAIN  = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_command == fcvm_pkg::CMD_TICK) state_in = ST_TIMER;
               else if (req_command == fcvm_pkg::CMD_SET_RPM) state_in = ST_DEN;
               else state_in = ST_DONE;
            end
         end
         ST_DEN: begin
            cmd.den  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_TIMER: begin
            cmd.timer = 1'b1;
            state_in  = sts.fire_now ? ST_REDUCE : ST_MIX;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (!sts.pos_ge) state_in = ST_FIRE;
         end
         ST_FIRE: begin
            cmd.fire = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            if (sts.voice_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FCVM_ASSERT(a_state_onehot, clock, reset, $onehot(state_ff))
   `FCVM_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_valid_ff)
   `FCVM_ASSERT_NEXT(a_done_free_idle, clock, reset,
      (state_ff == ST_DONE) && !rsp_valid_ff, state_ff == ST_IDLE)
   `FCVM_ASSERT_NEXT(a_no_fire_to_mix, clock, reset,
      (state_ff == ST_TIMER) && !sts.fire_now, state_ff == ST_MIX)
endmodule
`default_nettype wire

// ===== rtl/fcvm_dp.sv =====
// Datapath: tables, click memory, divider, phase timer, voice pool and mixer.
`default_nettype none
module fcvm_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fcvm_pkg::cmd_type    cmd,
   output fcvm_pkg::status_type      sts,
   input  wire logic [2:0]           req_command,
   input  wire logic [15:0]          req_rpm_value,
   input  wire logic [3:0]           req_slot,
   input  wire logic [3:0]           req_piston,
   input  wire logic [11:0]          req_sample_index,
   input  wire logic signed [15:0]   req_sample_value,
   input  wire logic [10:0]          req_interval_factor,
   input  wire logic [12:0]          req_click_length,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [17:0]          csr_data,
   output logic signed [15:0]        rsp_sample_out,
   output logic                      rsp_fired,
   output logic [3:0]                rsp_fired_cylinder,
   output logic                      rsp_dropped,
   output logic                      rsp_clipped,
   output logic [15:0]               rsp_rpm_readback
);
   localparam int CW = fcvm_pkg::CYL_W;
   localparam int VW = fcvm_pkg::VOICE_W;
   localparam int PW = fcvm_pkg::POS_W;
   localparam int AW = fcvm_pkg::ADDR_W;
   localparam int NW = fcvm_pkg::NUM_W;
   localparam int ACW = fcvm_pkg::ACC_W;
   localparam int DCNT_W_L = fcvm_pkg::DCNT_W;

   // configuration
   logic [4:0]  cyl_count_ff;
   logic [15:0] rpm_factor_ff;
   logic [17:0] sample_rate_ff;
   logic [15:0] max_amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_count_ff   <= 5'd4;
         rpm_factor_ff  <= 16'd4096;
         sample_rate_ff <= 18'd48000;
         max_amp_ff     <= 16'd32768;
      end else if (csr_write) begin
         unique case (csr_index)
            fcvm_pkg::REG_CYL_COUNT:  cyl_count_ff   <= csr_data[4:0];
            fcvm_pkg::REG_RPM_FACTOR: rpm_factor_ff  <= csr_data[15:0];
            fcvm_pkg::REG_SAMPLE_RT:  sample_rate_ff <= csr_data;
            fcvm_pkg::REG_MAX_AMP:    max_amp_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // tables and click memory
   logic [CW-1:0] forder_ff [fcvm_pkg::MAX_CYLINDERS];
   logic [10:0]   factor_ff [fcvm_pkg::MAX_CYLINDERS];
   logic [12:0]   clen_ff   [fcvm_pkg::MAX_CYLINDERS];
   logic [15:0]   click_mem [fcvm_pkg::MEM_DEPTH];
   logic          slot_ok, piston_ok, index_ok;

   assign slot_ok   = 32'(req_slot) < fcvm_pkg::MAX_CYLINDERS;
   assign piston_ok = 32'(req_piston) < fcvm_pkg::MAX_CYLINDERS;
   assign index_ok  = 32'(req_sample_index) < fcvm_pkg::CLICK_DEPTH;

   always_ff @(posedge clock) begin
      if (cmd.accept && slot_ok) begin
         if (req_command == fcvm_pkg::CMD_WR_SLOT && piston_ok)
            forder_ff[req_slot[CW-1:0]] <= req_piston[CW-1:0];
         if (req_command == fcvm_pkg::CMD_WR_CYL) begin
            factor_ff[req_slot[CW-1:0]] <= req_interval_factor;
            clen_ff[req_slot[CW-1:0]]   <= req_click_length;
         end
      end
   end

   // rpm and interval divider
   logic [15:0]   cur_rpm_ff;
   logic [31:0]   interval_ff;
   logic [31:0]   den_ff;
   logic [NW-1:0] num_ff, quo_ff, quo_next;
   logic [32:0]   rem_ff, rem_sh;
   logic [DCNT_W_L-1:0] dcnt_ff;
   logic [23:0]   sr60;
   logic          dge;

   assign sr60     = ({6'b0, sample_rate_ff} << 6) - ({6'b0, sample_rate_ff} << 2);
   assign rem_sh   = {rem_ff[31:0], num_ff[NW-1]};
   assign dge      = rem_sh >= {1'b0, den_ff};
   assign quo_next = {quo_ff[NW-2:0], dge};
   assign sts.div_last = (dcnt_ff == DCNT_W_L'(NW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_rpm_ff  <= '0;
         interval_ff <= '1;
      end else begin
         if (cmd.accept && req_command == fcvm_pkg::CMD_SET_RPM)
            cur_rpm_ff <= req_rpm_value;
         if (cmd.div && sts.div_last) begin
            if (den_ff == '0 || quo_next[NW-1:32] != '0) interval_ff <= '1;
            else interval_ff <= quo_next[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.den) begin
         den_ff  <= cur_rpm_ff * rpm_factor_ff;
         num_ff  <= {sr60, 28'b0};
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div) begin
         rem_ff  <= dge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff  <= quo_next;
         num_ff  <= num_ff << 1;
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // phase timer and firing
   logic signed [33:0] timer_ff, timer_inc;
   logic signed [34:0] timer_sum;
   logic signed [35:0] timer_diff;
   logic [3:0]         phase_ff, pos_ff;
   logic [4:0]         cnt_eff, pos_plus;
   logic [42:0]        fprod_ff;
   logic [CW-1:0]      fcyl;
   logic               any_idle;
   logic [VW-1:0]      idle_idx;
   logic [fcvm_pkg::MAX_VOICES-1:0] vact_ff;

   assign timer_sum = 35'(timer_ff) + 35'sd65536;
   assign timer_inc = (timer_sum > 35'sd8589934591) ? 34'sh1_FFFF_FFFF : timer_sum[33:0];
   assign sts.fire_now = (interval_ff != '1) && (timer_inc >= $signed({2'b0, interval_ff}));
   assign cnt_eff = (cyl_count_ff == 5'd0) ? 5'd1 :
                    (32'(cyl_count_ff) > fcvm_pkg::MAX_CYLINDERS) ?
                    5'(fcvm_pkg::MAX_CYLINDERS) : cyl_count_ff;
   assign sts.pos_ge = {1'b0, pos_ff} >= cnt_eff;
   assign pos_plus   = {1'b0, pos_ff} + 5'd1;
   assign fcyl       = forder_ff[pos_ff[CW-1:0]];
   assign timer_diff = 36'(timer_ff) - $signed({1'b0, fprod_ff[42:8]});

   always_comb begin
      any_idle = 1'b0;
      idle_idx = '0;
      for (int i = fcvm_pkg::MAX_VOICES - 1; i >= 0; i--) begin
         if (!vact_ff[i]) begin
            any_idle = 1'b1;
            idle_idx = VW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         phase_ff <= '0;
      end else begin
         if (cmd.timer) timer_ff <= timer_inc;
         else if (cmd.sub)
            timer_ff <= (timer_diff < -36'sd8589934592) ? 34'sh2_0000_0000 : timer_diff[33:0];
         if (cmd.fire) phase_ff <= (pos_plus >= cnt_eff) ? 4'd0 : pos_plus[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.timer) pos_ff <= phase_ff;
      else if (cmd.reduce && sts.pos_ge) pos_ff <= pos_ff - cnt_eff[3:0];
      if (cmd.fire) fprod_ff <= factor_ff[fcyl] * interval_ff;
   end

   // voice pool and mix pipeline
   logic [CW-1:0] vcyl_ff [fcvm_pkg::MAX_VOICES];
   logic [PW-1:0] vpos_ff [fcvm_pkg::MAX_VOICES];
   logic [VW-1:0] vidx_ff;
   logic [CW-1:0] mcyl;
   logic [PW-1:0] mpos;
   logic [12:0]   mlen, mlen_eff;
   logic          hit0, hit1_ff, hit2_ff;
   logic [15:0]   mem_q_ff;
   logic signed [fcvm_pkg::PROD_W-1:0] mprod_ff;
   logic signed [ACW-1:0] acc_ff;
   logic [16:0]   gain;

   assign gain     = (max_amp_ff > 16'd32768) ? 17'd32768 : {1'b0, max_amp_ff};
   assign mcyl     = vcyl_ff[vidx_ff];
   assign mpos     = vpos_ff[vidx_ff];
   assign mlen     = clen_ff[mcyl];
   assign mlen_eff = (32'(mlen) > fcvm_pkg::CLICK_DEPTH) ? 13'(fcvm_pkg::CLICK_DEPTH) : mlen;
   assign hit0     = vact_ff[vidx_ff] && (32'(mpos) < 32'(mlen_eff));
   assign sts.voice_last = (32'(vidx_ff) == fcvm_pkg::MAX_VOICES - 1);
   assign sts.pipe_busy  = hit1_ff || hit2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vact_ff <= '0;
      end else if (cmd.fire && any_idle) begin
         vact_ff[idle_idx] <= 1'b1;
      end else if (cmd.mix && vact_ff[vidx_ff] && !hit0) begin
         vact_ff[vidx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire && any_idle) begin
         vcyl_ff[idle_idx] <= fcyl;
         vpos_ff[idle_idx] <= '0;
      end else if (cmd.mix && hit0) begin
         vpos_ff[vidx_ff] <= mpos + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_command == fcvm_pkg::CMD_WR_CLICK && slot_ok && index_ok)
         click_mem[{req_slot[CW-1:0], req_sample_index[AW-1:0]}] <= req_sample_value;
      mem_q_ff <= click_mem[{mcyl, mpos[AW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit1_ff <= 1'b0;
         hit2_ff <= 1'b0;
      end else begin
         hit1_ff <= cmd.mix && hit0;
         hit2_ff <= hit1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.timer) vidx_ff <= '0;
      else if (cmd.mix) vidx_ff <= vidx_ff + 1'b1;
      mprod_ff <= $signed(mem_q_ff) * $signed(gain);
      if (cmd.accept) acc_ff <= '0;
      else if (hit2_ff) acc_ff <= acc_ff + ACW'(mprod_ff);
   end

   // result flags and rounding
   logic              fired_ff, dropped_ff;
   logic [3:0]        fcyl_ff;
   logic signed [ACW-1:0] rsum;
   logic signed [ACW-16:0] rnd;
   logic              clip_hi, clip_lo;

   assign rsum    = acc_ff + ACW'(16384);
   assign rnd     = rsum[ACW-1:15];
   assign clip_hi = rnd > (ACW-15)'(32767);
   assign clip_lo = rnd < -(ACW-15)'(32768);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fired_ff   <= 1'b0;
         dropped_ff <= 1'b0;
         fcyl_ff    <= '0;
      end else if (cmd.fire) begin
         fired_ff   <= any_idle;
         dropped_ff <= !any_idle;
         fcyl_ff    <= 4'(fcyl);
      end
      if (cmd.load_out) begin
         rsp_sample_out     <= clip_hi ? 16'sh7FFF : clip_lo ? -16'sh8000 : rnd[15:0];
         rsp_clipped        <= clip_hi || clip_lo;
         rsp_fired          <= fired_ff;
         rsp_dropped        <= dropped_ff;
         rsp_fired_cylinder <= fcyl_ff;
         rsp_rpm_readback   <= cur_rpm_ff;
      end
   end
endmodule
`default_nettype wire
